// File: sv/seg7w_pkg.sv
package seg7w_pkg;

    // Command kinds
    localparam logic [1:0] KIND_PUT_CHAR  = 2'd0;
    localparam logic [1:0] KIND_SET_DIGIT = 2'd1;
    localparam logic [1:0] KIND_PRINT_NUM = 2'd2;
    localparam logic [1:0] KIND_SET_EN    = 2'd3;

    // Device addresses and fixed bytes
    localparam logic [6:0]  ADDR_CTRL   = 7'h24;
    localparam logic [6:0]  ADDR_DIGIT0 = 7'h34;
    localparam logic [7:0]  DP_BIT      = 8'h80;
    localparam logic [7:0]  CR_CODE     = 8'd13;
    localparam logic [7:0]  CHAR_ZERO   = 8'd48;
    localparam logic [7:0]  CHAR_E      = 8'h45;
    localparam logic [7:0]  CHAR_FIRST  = 8'd32;
    localparam logic [15:0] NUM_LIMIT   = 16'd10000;

    localparam int NUM_DIGITS = 4;

    // Segment patterns for codes 32..127, bit 7 is the decimal point
    localparam logic [7:0] SEG_TABLE [96] = '{
        8'h00, 8'h82, 8'h21, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02,
        8'h39, 8'h0F, 8'h00, 8'h00, 8'h00, 8'h40, 8'h80, 8'h00,
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h48, 8'h00, 8'h53,
        8'h00, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h6F,
        8'h76, 8'h06, 8'h1E, 8'h00, 8'h38, 8'h00, 8'h54, 8'h3F,
        8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h3E, 8'h00, 8'h00,
        8'h00, 8'h6E, 8'h00, 8'h39, 8'h00, 8'h0F, 8'h00, 8'h08,
        8'h63, 8'h5F, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h71, 8'h6F,
        8'h74, 8'h02, 8'h1E, 8'h00, 8'h06, 8'h00, 8'h54, 8'h5C,
        8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h00, 8'h00,
        8'h00, 8'h6E, 8'h00, 8'h39, 8'h30, 8'h0F, 8'h00, 8'h00
    };

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  character;
        logic [7:0]  digit_pos;
        logic        decimal_point;
        logic [15:0] number;
        logic        enable_on;
    } in_word_t;

    typedef struct packed {
        logic [6:0] bus_address;
        logic [7:0] bus_data;
        logic       last;
        logic       display_on;
    } out_word_t;

    // Up to four writes handed to the serializer, entry 0 goes out first
    typedef struct packed {
        logic                            disp;
        logic [NUM_DIGITS-1:0][6:0]      addr;
        logic [NUM_DIGITS-1:0][7:0]      data;
    } seg7w_burst_t;

    // Segment pattern of a character; codes outside 32..127 are blank
    function automatic logic [7:0] glyph(input logic [7:0] ch);
        logic [6:0] idx;
        idx = ch[6:0] - CHAR_FIRST[6:0];
        if (ch < CHAR_FIRST || ch[7])
            return 8'h00;
        return SEG_TABLE[idx];
    endfunction

endpackage

// File: sv/seg7w_burst.sv
module seg7w_burst (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load_valid,
    output logic                    load_ready,
    input  logic [2:0]              load_cnt,
    input  seg7w_pkg::seg7w_burst_t load,
    output logic                    wr_valid,
    input  logic                    wr_ready,
    output seg7w_pkg::out_word_t    wr
);

    logic [2:0]              cnt_reg;
    logic [2:0]              cnt_next;
    seg7w_pkg::seg7w_burst_t burst_reg;
    seg7w_pkg::seg7w_burst_t burst_next;
    logic                    wr_fire;

    assign wr_fire    = wr_valid && wr_ready;
    assign wr_valid   = (cnt_reg != 3'd0);
    // free when empty, or when the final word leaves this cycle
    assign load_ready = (cnt_reg == 3'd0) || (wr_ready && (cnt_reg == 3'd1));

    // current word is always entry 0
    assign wr.bus_address = burst_reg.addr[0];
    assign wr.bus_data    = burst_reg.data[0];
    assign wr.last        = (cnt_reg == 3'd1);
    assign wr.display_on  = burst_reg.disp;

    // load a new burst or shift the remaining entries down
    always_comb
    begin
        cnt_next   = cnt_reg;
        burst_next = burst_reg;
        if (load_valid && load_ready)
        begin
            cnt_next   = load_cnt;
            burst_next = load;
        end
        else if (wr_fire)
        begin
            cnt_next = cnt_reg - 3'd1;
            for (int i = 0; i < seg7w_pkg::NUM_DIGITS - 1; i++)
            begin
                burst_next.addr[i] = burst_reg.addr[i+1];
                burst_next.data[i] = burst_reg.data[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 3'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        burst_reg <= burst_next;
    end

endmodule

// File: sv/seven_segment_text_number_writer_top.sv
// Turns display commands into bus writes (device address plus data byte) for a four-digit
// seven-segment controller, one write per cycle on the wr port while wr_ready is high. Clear
// and print-number make four writes, put-char, set-digit and set-enable one, and a put-char
// on a full cursor or a set-digit beyond digit 3 makes none. The first write of a command
// passes through stage 1, stage 2 and the burst register; a command is taken each cycle
// while the pipeline has room, so the sustained rate is set by the single write port.
// Numbers are split into decimal digits over the pipeline stages (thousands, hundreds,
// tens and ones).
module seven_segment_text_number_writer_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  seg7w_pkg::in_word_t  cmd,
    output logic                 wr_valid,
    input  logic                 wr_ready,
    output seg7w_pkg::out_word_t wr
);

    localparam logic [1:0] OP_CHAR  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_NUM   = 2'd2;
    localparam logic [1:0] OP_CTRL  = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] cnt;
        logic [1:0] idx;
        logic [7:0] ch;
        logic       dp;
        logic       en;
        logic       disp;
        logic       big;
    } plan_t;

    // command state
    logic [2:0] cursor_reg;
    logic [2:0] cursor_next;
    logic       disp_reg;
    logic       disp_next;
    plan_t      plan_next;
    logic       cmd_fire;

    // stage 1: thousands split
    logic       s1_valid_reg;
    plan_t      s1_plan_reg;
    logic [3:0] s1_dig3_reg;
    logic [9:0] s1_rem_reg;
    logic [3:0] dig3_next;
    logic [9:0] rem1_next;

    // stage 2: hundreds split
    logic       s2_valid_reg;
    plan_t      s2_plan_reg;
    logic [3:0] s2_dig3_reg;
    logic [3:0] s2_dig2_reg;
    logic [6:0] s2_rem_reg;
    logic [3:0] dig2_next;
    logic [6:0] rem2_next;

    // burst assembly
    logic [3:0]              dig1;
    logic [3:0]              dig0;
    logic                    nz0;
    logic                    nz1;
    logic                    nz2;
    seg7w_pkg::seg7w_burst_t burst;
    logic                    load_ready;
    logic                    load_valid;
    logic                    s1_ready;
    logic                    s1_adv;
    logic                    s2_ready;
    logic                    s2_adv;

    // pipeline flow; commands that write nothing retire at stage 2
    assign s2_adv    = s2_valid_reg && ((s2_plan_reg.cnt == 3'd0) || load_ready);
    assign s2_ready  = !s2_valid_reg || s2_adv;
    assign s1_adv    = s1_valid_reg && s2_ready;
    assign s1_ready  = !s1_valid_reg || s1_adv;
    assign cmd_ready = s1_ready;
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign load_valid = s2_adv && (s2_plan_reg.cnt != 3'd0);

    // decode command and update cursor / display state
    always_comb
    begin
        cursor_next    = cursor_reg;
        disp_next      = disp_reg;
        plan_next      = '0;
        plan_next.ch   = cmd.character;
        plan_next.en   = cmd.enable_on;
        plan_next.big  = (cmd.number >= seg7w_pkg::NUM_LIMIT);
        unique case (cmd.kind)
            seg7w_pkg::KIND_PUT_CHAR:
            begin
                if (cmd.character == seg7w_pkg::CR_CODE)
                begin
                    plan_next.op  = OP_CLEAR;
                    plan_next.cnt = 3'd4;
                    cursor_next   = 3'd0;
                end
                else if (!cursor_reg[2])
                begin
                    plan_next.op  = OP_CHAR;
                    plan_next.cnt = 3'd1;
                    plan_next.idx = cursor_reg[1:0];
                    cursor_next   = cursor_reg + 3'd1;
                end
                else
                begin
                    plan_next.op  = OP_CHAR;
                    plan_next.cnt = 3'd0;
                end
            end
            seg7w_pkg::KIND_SET_DIGIT:
            begin
                plan_next.op  = OP_CHAR;
                plan_next.idx = cmd.digit_pos[1:0];
                plan_next.dp  = cmd.decimal_point;
                plan_next.cnt = (cmd.digit_pos[7:2] == 6'd0) ? 3'd1 : 3'd0;
            end
            seg7w_pkg::KIND_PRINT_NUM:
            begin
                plan_next.op  = OP_NUM;
                plan_next.cnt = 3'd4;
            end
            seg7w_pkg::KIND_SET_EN:
            begin
                plan_next.op  = OP_CTRL;
                plan_next.cnt = 3'd1;
                disp_next     = cmd.enable_on;
            end
        endcase
        plan_next.disp = disp_next;
    end

    // thousands digit: parallel compares against constant multiples
    always_comb
    begin
        logic [13:0] v;
        logic [13:0] sub;
        v         = cmd.number[13:0];
        dig3_next = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (v >= 14'(k * 1000))
                dig3_next = 4'(k);
        end
        sub       = v - 14'(dig3_next) * 14'd1000;
        rem1_next = sub[9:0];
    end

    // hundreds digit
    always_comb
    begin
        logic [9:0] sub;
        dig2_next = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (s1_rem_reg >= 10'(k * 100))
                dig2_next = 4'(k);
        end
        sub       = s1_rem_reg - 10'(dig2_next) * 10'd100;
        rem2_next = sub[6:0];
    end

    // tens and ones digits, then the write list
    always_comb
    begin
        logic [6:0] sub;
        dig1 = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (s2_rem_reg >= 7'(k * 10))
                dig1 = 4'(k);
        end
        sub  = s2_rem_reg - 7'(dig1) * 7'd10;
        dig0 = sub[3:0];

        // leading digits are blank until the value reaches their weight
        nz0 = (s2_dig3_reg != 4'd0);
        nz1 = nz0 || (s2_dig2_reg != 4'd0);
        nz2 = nz1 || (dig1 != 4'd0);

        burst.disp = s2_plan_reg.disp;
        for (int i = 0; i < seg7w_pkg::NUM_DIGITS; i++)
        begin
            burst.addr[i] = seg7w_pkg::ADDR_DIGIT0 + 7'(i);
            burst.data[i] = 8'h00;
        end

        unique case (s2_plan_reg.op)
            OP_CHAR:
            begin
                burst.addr[0] = seg7w_pkg::ADDR_DIGIT0 + {5'd0, s2_plan_reg.idx};
                burst.data[0] = seg7w_pkg::glyph(s2_plan_reg.ch)
                              | (s2_plan_reg.dp ? seg7w_pkg::DP_BIT : 8'h00);
            end
            OP_CLEAR:
            begin
                // addresses and blank data already set
            end
            OP_NUM:
            begin
                if (s2_plan_reg.big)
                begin
                    for (int i = 0; i < seg7w_pkg::NUM_DIGITS; i++)
                        burst.data[i] = seg7w_pkg::glyph(seg7w_pkg::CHAR_E);
                end
                else
                begin
                    burst.data[0] = nz0 ? seg7w_pkg::glyph(seg7w_pkg::CHAR_ZERO
                                                           + {4'd0, s2_dig3_reg}) : 8'h00;
                    burst.data[1] = nz1 ? seg7w_pkg::glyph(seg7w_pkg::CHAR_ZERO
                                                           + {4'd0, s2_dig2_reg}) : 8'h00;
                    burst.data[2] = nz2 ? seg7w_pkg::glyph(seg7w_pkg::CHAR_ZERO
                                                           + {4'd0, dig1}) : 8'h00;
                    burst.data[3] = seg7w_pkg::glyph(seg7w_pkg::CHAR_ZERO + {4'd0, dig0});
                end
            end
            OP_CTRL:
            begin
                burst.addr[0] = seg7w_pkg::ADDR_CTRL;
                burst.data[0] = {7'd0, s2_plan_reg.en};
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg   <= 3'd0;
            disp_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_fire)
            begin
                cursor_reg <= cursor_next;
                disp_reg   <= disp_next;
            end
            if (s1_ready)
                s1_valid_reg <= cmd_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            s1_plan_reg <= plan_next;
            s1_dig3_reg <= dig3_next;
            s1_rem_reg  <= rem1_next;
        end
        if (s1_adv)
        begin
            s2_plan_reg <= s1_plan_reg;
            s2_dig3_reg <= s1_dig3_reg;
            s2_dig2_reg <= dig2_next;
            s2_rem_reg  <= rem2_next;
        end
    end

    seg7w_burst u_burst (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (load_valid),
        .load_ready (load_ready),
        .load_cnt   (s2_plan_reg.cnt),
        .load       (burst),
        .wr_valid   (wr_valid),
        .wr_ready   (wr_ready),
        .wr         (wr)
    );

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int RAND_ITEMS   = 360;
    localparam int HOLD_CYCLES  = 150;
    localparam int HOLD_AFTER   = 120;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [7:0] BLANK    = 8'h00;
    localparam logic [7:0] CTRL_ON  = 8'h01;
    localparam logic [7:0] CTRL_OFF = 8'h00;

    // Segment patterns for codes 32..127
    localparam logic [7:0] SEG_ROM [96] = '{
        8'h00, 8'h82, 8'h21, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02,
        8'h39, 8'h0F, 8'h00, 8'h00, 8'h00, 8'h40, 8'h80, 8'h00,
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h48, 8'h00, 8'h53,
        8'h00, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h6F,
        8'h76, 8'h06, 8'h1E, 8'h00, 8'h38, 8'h00, 8'h54, 8'h3F,
        8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h3E, 8'h00, 8'h00,
        8'h00, 8'h6E, 8'h00, 8'h39, 8'h00, 8'h0F, 8'h00, 8'h08,
        8'h63, 8'h5F, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h71, 8'h6F,
        8'h74, 8'h02, 8'h1E, 8'h00, 8'h06, 8'h00, 8'h54, 8'h5C,
        8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h00, 8'h00,
        8'h00, 8'h6E, 8'h00, 8'h39, 8'h30, 8'h0F, 8'h00, 8'h00
    };

    // Directed row: command plus, where typed, the writes it must cause.
    // Write k goes to addr0+k with byte k taken from the top of bytes.
    typedef struct packed {
        seg7w_pkg::in_word_t w;
        logic       typed;
        logic [2:0] n;
        logic [6:0] addr0;
        logic [31:0] bytes;
        logic       disp;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       cmd_valid;
    logic       cmd_ready;
    seg7w_pkg::in_word_t   cmd;
    logic       wr_valid;
    logic       wr_ready;
    seg7w_pkg::out_word_t  wr;

    // Shadow display state
    logic [2:0] cur_pos;
    logic       disp_on;

    seg7w_pkg::out_word_t  predicted_writes [$];
    seg7w_pkg::out_word_t  pending_writes [$];
    dir_row_t   dir_tab [$];

    int errors;
    int cmds_taken;
    int writes_seen;
    int kind_count [4];
    int burst_left;

    seven_segment_text_number_writer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .wr_valid  (wr_valid),
        .wr_ready  (wr_ready),
        .wr        (wr)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [7:0] segment_of(input logic [7:0] ch);
        if (ch < 8'd32 || ch > 8'd127)
            return BLANK;
        return SEG_ROM[ch - 8'd32];
    endfunction

    // Writes caused by one command, in bus order; updates cursor and display state
    task automatic predict_writes(input seg7w_pkg::in_word_t w);
        logic [7:0] pat [4];
        int v;
        predicted_writes.delete();
        case (w.kind)
            seg7w_pkg::KIND_PUT_CHAR:
            begin
                if (w.character == seg7w_pkg::CR_CODE)
                begin
                    for (int i = 0; i < 4; i++)
                        predicted_writes.push_back(seg7w_pkg::out_word_t'{
                            7'(seg7w_pkg::ADDR_DIGIT0 + i), BLANK, 1'b0, 1'b0});
                    cur_pos = 3'd0;
                end
                else if (cur_pos < 3'd4)
                begin
                    predicted_writes.push_back(seg7w_pkg::out_word_t'{
                        seg7w_pkg::ADDR_DIGIT0 + cur_pos, segment_of(w.character),
                        1'b0, 1'b0});
                    cur_pos = cur_pos + 3'd1;
                end
            end
            seg7w_pkg::KIND_SET_DIGIT:
            begin
                if (w.digit_pos <= 8'd3)
                    predicted_writes.push_back(seg7w_pkg::out_word_t'{
                        seg7w_pkg::ADDR_DIGIT0 + w.digit_pos[1:0],
                        segment_of(w.character) | (w.decimal_point ? seg7w_pkg::DP_BIT : BLANK),
                        1'b0, 1'b0});
            end
            seg7w_pkg::KIND_PRINT_NUM:
            begin
                if (w.number >= seg7w_pkg::NUM_LIMIT)
                begin
                    for (int i = 0; i < 4; i++)
                        pat[i] = segment_of(seg7w_pkg::CHAR_E);
                end
                else
                begin
                    v = int'(w.number);
                    for (int i = 3; i >= 0; i--)
                    begin
                        // leading zeros blank, but digit 3 always shown
                        if (i == 3 || v != 0)
                            pat[i] = segment_of(seg7w_pkg::CHAR_ZERO + 8'(v % 10));
                        else
                            pat[i] = BLANK;
                        v = v / 10;
                    end
                end
                for (int i = 0; i < 4; i++)
                    predicted_writes.push_back(seg7w_pkg::out_word_t'{
                        7'(seg7w_pkg::ADDR_DIGIT0 + i), pat[i], 1'b0, 1'b0});
            end
            default:
            begin
                disp_on = w.enable_on;
                predicted_writes.push_back(seg7w_pkg::out_word_t'{seg7w_pkg::ADDR_CTRL,
                                           w.enable_on ? CTRL_ON : CTRL_OFF, 1'b0, 1'b0});
            end
        endcase
        foreach (predicted_writes[i])
        begin
            predicted_writes[i].display_on = disp_on;
            predicted_writes[i].last = (i == predicted_writes.size() - 1);
        end
    endtask

    function automatic seg7w_pkg::in_word_t mk_cmd(input logic [1:0] kind,
                                                   input logic [7:0] ch,
                                                   input logic [7:0] pos, input logic dp,
                                                   input logic [15:0] num, input logic en);
        return seg7w_pkg::in_word_t'{kind, ch, pos, dp, num, en};
    endfunction

    function automatic dir_row_t dir_row(input seg7w_pkg::in_word_t w, input logic typed,
                                         input logic [2:0] n, input logic [6:0] addr0,
                                         input logic [31:0] bytes, input logic disp);
        return dir_row_t'{w, typed, n, addr0, bytes, disp};
    endfunction

    // Random command; fields a kind ignores are random as well
    function automatic seg7w_pkg::in_word_t rand_cmd();
        seg7w_pkg::in_word_t w;
        int sel;
        w.kind = 2'($urandom);
        sel = $urandom_range(0, 9);
        if (sel < 6)
            w.character = 8'($urandom_range(32, 127));
        else if (sel == 6)
            w.character = seg7w_pkg::CR_CODE;
        else
            w.character = 8'($urandom);
        w.digit_pos = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        w.decimal_point = 1'($urandom);
        case ($urandom_range(0, 4))
            0: w.number = 16'($urandom_range(0, 9));
            1: w.number = 16'($urandom_range(0, 9999));
            2: w.number = 16'($urandom_range(9990, 10010));
            3: w.number = 16'($urandom_range(0, 999));
            default: w.number = 16'($urandom);
        endcase
        w.enable_on = 1'($urandom);
        return w;
    endfunction

    // Offer one word in bursts with random gaps; returns at the accepting edge
    task automatic send_cmd(input seg7w_pkg::in_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cmd_valid <= 1'b1;
        cmd <= w;
        do
            @(posedge clk);
        while (!cmd_ready);
        predict_writes(w);
        kind_count[w.kind]++;
        cmds_taken++;
    endtask

    // Write sink: rotating stall patterns plus one long hold-off
    initial
    begin : write_sink
        int cyc;
        bit held;
        wr_ready <= 1'b0;
        cyc = 0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (!held && cmds_taken >= HOLD_AFTER)
            begin
                held = 1'b1;
                wr_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                case ((cyc / 64) % 4)
                    0: wr_ready <= 1'b1;
                    1: wr_ready <= 1'($urandom_range(0, 1));
                    2: wr_ready <= ($urandom_range(0, 9) < 8);
                    default: wr_ready <= (cyc % 3 == 0);
                endcase
            end
        end
    end

    // Compare every accepted write with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && wr_valid && wr_ready)
        begin
            writes_seen++;
            if (pending_writes.size() == 0)
            begin
                $display("%0t: unexpected write addr=%h data=%h last=%b on=%b",
                         $realtime, wr.bus_address, wr.bus_data, wr.last, wr.display_on);
                errors++;
            end
            else
            begin
                if (wr !== pending_writes[0])
                begin
                    // fields in order: addr data last on
                    $display("%0t: write expected %h %h %b %b, got %h %h %b %b",
                             $realtime, pending_writes[0].bus_address,
                             pending_writes[0].bus_data, pending_writes[0].last,
                             pending_writes[0].display_on,
                             wr.bus_address, wr.bus_data, wr.last, wr.display_on);
                    errors++;
                end
                void'(pending_writes.pop_front());
            end
        end
    end

    // Watchdog: too long with no word moving on either channel
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && cmd_ready) || (wr_valid && wr_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial
    begin : main
        dir_row_t r;
        seg7w_pkg::in_word_t w;
        int line_left;
        rst_n <= 1'b0;
        cmd_valid <= 1'b0;
        cmd <= '0;
        cur_pos = 3'd0;
        disp_on = 1'b0;
        errors = 0;
        cmds_taken = 0;
        writes_seen = 0;
        burst_left = 0;
        line_left = 0;
        foreach (kind_count[i])
            kind_count[i] = 0;

        // Directed rows: extremes, every kind, clear, full cursor, bad digit, off-table codes
        dir_tab.push_back(dir_row(mk_cmd(seg7w_pkg::KIND_SET_EN, 0, 0, 0, 0, 0),
                                  1, 1, seg7w_pkg::ADDR_CTRL, 32'h00000000, 0));
        dir_tab.push_back(dir_row(mk_cmd(seg7w_pkg::KIND_PRINT_NUM, 0, 0, 0, 0, 0),
                                  1, 4, seg7w_pkg::ADDR_DIGIT0, 32'h0000003F, 0));
        dir_tab.push_back(dir_row(mk_cmd(seg7w_pkg::KIND_SET_EN, 0, 0, 0, 0, 1),
                                  1, 1, seg7w_pkg::ADDR_CTRL, 32'h01000000, 1));
        dir_tab.push_back(dir_row(mk_cmd(seg7w_pkg::KIND_PRINT_NUM, 0, 0, 0, 9999, 0),
                                  1, 4, seg7w_pkg::ADDR_DIGIT0, 32'h6F6F6F6F, 1));
        dir_tab.push_back(dir_row(mk_cmd(seg7w_pkg::KIND_PRINT_NUM, 0, 0, 0, 10000, 0),
                                  1, 4, seg7w_pkg::ADDR_DIGIT0, 32'h79797979, 1));
        dir_tab.push_back(dir_row(mk_cmd(seg7w_pkg::KIND_PRINT_NUM, 0, 0, 0, 16'hFFFF, 0),
                                  1, 4, seg7w_pkg::ADDR_DIGIT0, 32'h79797979, 1));
        dir_tab.push_back(dir_row(mk_cmd(seg7w_pkg::KIND_PRINT_NUM, 0, 0, 0, 1234, 0),
                                  0, 0, 0, 0, 0));
        dir_tab.push_back(dir_row(mk_cmd(seg7w_pkg::KIND_PRINT_NUM, 0, 0, 0, 100, 0),
                                  0, 0, 0, 0, 0));
        dir_tab.push_back(dir_row(mk_cmd(seg7w_pkg::KIND_PRINT_NUM, 0, 0, 0, 7, 0),
                                  0, 0, 0, 0, 0));
        dir_tab.push_back(dir_row(mk_cmd(seg7w_pkg::KIND_PUT_CHAR, 8'h41, 0, 0, 0, 0),
                                  0, 0, 0, 0, 0));
        dir_tab.push_back(dir_row(mk_cmd(seg7w_pkg::KIND_PUT_CHAR, 8'h00, 0, 0, 0, 0),
                                  0, 0, 0, 0, 0));
        dir_tab.push_back(dir_row(mk_cmd(seg7w_pkg::KIND_PUT_CHAR, 8'h7F, 0, 0, 0, 0),
                                  0, 0, 0, 0, 0));
        dir_tab.push_back(dir_row(mk_cmd(seg7w_pkg::KIND_PUT_CHAR, 8'hFF, 0, 0, 0, 0),
                                  0, 0, 0, 0, 0));
        // cursor is full: put-char writes nothing
        dir_tab.push_back(dir_row(mk_cmd(seg7w_pkg::KIND_PUT_CHAR, 8'h42, 0, 0, 0, 0),
                                  1, 0, 0, 0, 1));
        dir_tab.push_back(dir_row(mk_cmd(seg7w_pkg::KIND_PUT_CHAR, seg7w_pkg::CR_CODE,
                                         0, 0, 0, 0),
                                  1, 4, seg7w_pkg::ADDR_DIGIT0, 32'h00000000, 1));
        dir_tab.push_back(dir_row(mk_cmd(seg7w_pkg::KIND_PUT_CHAR, 8'd32, 0, 0, 0, 0),
                                  0, 0, 0, 0, 0));
        dir_tab.push_back(dir_row(mk_cmd(seg7w_pkg::KIND_SET_DIGIT, 8'h38, 0, 1, 0, 0),
                                  0, 0, 0, 0, 0));
        dir_tab.push_back(dir_row(mk_cmd(seg7w_pkg::KIND_SET_DIGIT, 8'hFF, 3, 1, 0, 0),
                                  1, 1, seg7w_pkg::ADDR_DIGIT0 + 7'd3, 32'h80000000, 1));
        dir_tab.push_back(dir_row(mk_cmd(seg7w_pkg::KIND_SET_DIGIT, 8'h41, 4, 1, 0, 0),
                                  1, 0, 0, 0, 1));
        dir_tab.push_back(dir_row(mk_cmd(seg7w_pkg::KIND_SET_DIGIT, 8'h41, 8'hFF, 1, 0, 0),
                                  1, 0, 0, 0, 1));
        dir_tab.push_back(dir_row(mk_cmd(seg7w_pkg::KIND_SET_EN, 0, 0, 0, 0, 0),
                                  1, 1, seg7w_pkg::ADDR_CTRL, 32'h00000000, 0));
        dir_tab.push_back(dir_row(mk_cmd(seg7w_pkg::KIND_PUT_CHAR, seg7w_pkg::CR_CODE,
                                         0, 0, 0, 0),
                                  1, 4, seg7w_pkg::ADDR_DIGIT0, 32'h00000000, 0));
        dir_tab.push_back(dir_row(mk_cmd(seg7w_pkg::KIND_SET_DIGIT, 8'd31, 2, 0, 0, 0),
                                  0, 0, 0, 0, 0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part
        foreach (dir_tab[i])
        begin
            r = dir_tab[i];
            send_cmd(r.w);
            if (r.typed)
            begin
                for (int k = 0; k < r.n; k++)
                    pending_writes.push_back(seg7w_pkg::out_word_t'{7'(r.addr0 + k),
                                             r.bytes[31 - 8 * k -: 8], (k == r.n - 1), r.disp});
            end
            else
                pending_writes = {pending_writes, predicted_writes};
        end

        // Random part: mostly text lines (clear then a run of chars), rest mixed commands
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            w = rand_cmd();
            if (line_left > 0)
            begin
                w.kind = seg7w_pkg::KIND_PUT_CHAR;
                if (w.character == seg7w_pkg::CR_CODE)
                    w.character = 8'h30;
                line_left--;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                w.kind = seg7w_pkg::KIND_PUT_CHAR;
                w.character = seg7w_pkg::CR_CODE;
                line_left = $urandom_range(1, 6);
            end
            send_cmd(w);
            pending_writes = {pending_writes, predicted_writes};
        end
        cmd_valid <= 1'b0;

        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d commands: %0d put-char, %0d set-digit, %0d print, %0d enable",
                 cmds_taken, kind_count[seg7w_pkg::KIND_PUT_CHAR],
                 kind_count[seg7w_pkg::KIND_SET_DIGIT],
                 kind_count[seg7w_pkg::KIND_PRINT_NUM], kind_count[seg7w_pkg::KIND_SET_EN]);
        $display("Checked %0d bus writes, %0d errors, with one long sink hold-off",
                 writes_seen, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
